@@ design/wwsc_pkg.sv @@
package wwsc_pkg;

    localparam int DATA_W = 32;
    localparam int CFG_W = 26;
    localparam int IDX_W = 3;
    localparam int STAMP_W = 48;
    localparam int COUNT_W = 10;
    localparam int STATUS_W = 2;
    localparam int LANES = 6;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_ACCEPTED = 2'd0;
    localparam logic [STATUS_W-1:0] ST_TOO_FEW = 2'd1;
    localparam logic [STATUS_W-1:0] ST_STALE = 2'd2;
    localparam logic [STATUS_W-1:0] ST_UNSTABLE = 2'd3;

    // register indexes
    localparam logic [IDX_W-1:0] REG_WINDOW = 3'd0;
    localparam logic [IDX_W-1:0] REG_MIN_STABLE = 3'd1;
    localparam logic [IDX_W-1:0] REG_FORCE_DEV = 3'd2;
    localparam logic [IDX_W-1:0] REG_TORQUE_DEV = 3'd3;
    localparam logic [IDX_W-1:0] REG_TIMEOUT = 3'd4;

    localparam logic [CFG_W-1:0] COUNT_MAX = 26'd1000;
    localparam logic [CFG_W-1:0] TIMEOUT_MAX = 26'd60000000;

    // lane control from the walk sequencer
    typedef struct packed {
        logic clr;
        logic rd;
        logic start;
    } lane_ctl_t;

    // lane status back to the merge stage
    typedef struct packed {
        logic done;
        logic unstable;
    } lane_sts_t;

endpackage

@@ design/wwsc_ram.sv @@
module wwsc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ design/wwsc_lane.sv @@
module wwsc_lane import wwsc_pkg::*; #(
    parameter int WINDOW_DEPTH = 1024
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              wr_en,
    input  logic [$clog2(WINDOW_DEPTH)-1:0]   wr_addr,
    input  logic [DATA_W-1:0]                 wr_data,
    input  logic [$clog2(WINDOW_DEPTH)-1:0]   rd_addr,
    input  lane_ctl_t                         ctl,
    input  logic [$clog2(WINDOW_DEPTH+1)-1:0] n,
    input  logic [CFG_W-1:0]                  thr,
    output lane_sts_t                         sts,
    output logic [DATA_W-1:0]                 mean
);

    localparam int CW = $clog2(WINDOW_DEPTH + 1);
    localparam int SW = DATA_W + CW;
    localparam int QW = 2 * DATA_W + CW;
    localparam int PW = 2 * DATA_W + 2 * CW;
    localparam int BW = SW;
    localparam int KW = $clog2(BW + 1);

    localparam logic [2:0] P_IDLE = 3'd0;
    localparam logic [2:0] P_NT = 3'd1;
    localparam logic [2:0] P_TT = 3'd2;
    localparam logic [2:0] P_NQ = 3'd3;
    localparam logic [2:0] P_SS = 3'd4;
    localparam logic [2:0] P_DIV = 3'd5;
    localparam logic [2:0] P_DONE = 3'd6;

    logic [DATA_W-1:0] x;
    logic v1_reg, v2_reg;
    logic [2*DATA_W-1:0] sq_reg;
    logic signed [DATA_W-1:0] xd_reg;
    logic signed [SW-1:0] sum_reg;
    logic [QW-1:0] sqs_reg;
    logic signed [2*DATA_W-1:0] prod;
    logic [SW-1:0] sum_mag;

    logic [2:0] phase_reg;
    logic [PW-1:0] acc_reg, a_reg, rhs_reg, lhs_reg, acc_next;
    logic [BW-1:0] b_reg;
    logic [KW-1:0] cnt_reg;
    logic unstable_reg;
    logic [CW:0] rem_reg, rem_try;
    logic [SW-1:0] quo_reg;
    logic last;

    wwsc_ram #(.WIDTH(DATA_W), .DEPTH(WINDOW_DEPTH)) u_ram (
        .clk   (clk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (wr_data),
        .re    (ctl.rd),
        .raddr (rd_addr),
        .rdata (x)
    );

    // square of the word just read
    assign prod = $signed(x) * $signed(x);
    assign sum_mag = sum_reg[SW-1] ? SW'(-sum_reg) : SW'(sum_reg);

    // walk pipeline: read, square, accumulate
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= ctl.rd;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        sq_reg <= prod;
        xd_reg <= $signed(x);
        if (ctl.clr)
        begin
            sum_reg <= '0;
            sqs_reg <= '0;
        end
        else if (v2_reg)
        begin
            sum_reg <= sum_reg + SW'(xd_reg);
            sqs_reg <= sqs_reg + QW'(sq_reg);
        end
    end

    // shift-add multiplier step and restoring divider step
    assign acc_next = acc_reg + (b_reg[0] ? a_reg : '0);
    assign last = (cnt_reg == KW'(BW - 1));
    assign rem_try = {rem_reg[CW-1:0], b_reg[BW-1]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= P_IDLE;
        end
        else if (ctl.clr)
        begin
            phase_reg <= P_IDLE;
        end
        else if (ctl.start)
        begin
            phase_reg <= P_NT;
        end
        else if (last)
        begin
            case (phase_reg)
                P_NT: phase_reg <= P_TT;
                P_TT: phase_reg <= P_NQ;
                P_NQ: phase_reg <= P_SS;
                P_SS: phase_reg <= P_DIV;
                P_DIV: phase_reg <= P_DONE;
                default: phase_reg <= phase_reg;
            endcase
        end
    end

    // post-walk math: (n*thr)^2, n*sum_sq, sum^2, then mean
    always_ff @(posedge clk)
    begin
        if (ctl.start)
        begin
            acc_reg <= '0;
            a_reg <= PW'(thr);
            b_reg <= BW'(n);
            cnt_reg <= '0;
        end
        else if (phase_reg == P_DIV)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            b_reg <= b_reg << 1;
            if (rem_try >= (CW+1)'(n))
            begin
                rem_reg <= rem_try - (CW+1)'(n);
                quo_reg <= {quo_reg[SW-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem_try;
                quo_reg <= {quo_reg[SW-2:0], 1'b0};
            end
        end
        else if (phase_reg != P_IDLE && phase_reg != P_DONE)
        begin
            cnt_reg <= last ? '0 : cnt_reg + 1'b1;
            if (!last)
            begin
                acc_reg <= acc_next;
                a_reg <= a_reg << 1;
                b_reg <= b_reg >> 1;
            end
            else
            begin
                acc_reg <= '0;
                case (phase_reg)
                    P_NT:
                    begin
                        a_reg <= acc_next;
                        b_reg <= acc_next[BW-1:0];
                    end
                    P_TT:
                    begin
                        rhs_reg <= acc_next;
                        a_reg <= PW'(sqs_reg);
                        b_reg <= BW'(n);
                    end
                    P_NQ:
                    begin
                        lhs_reg <= acc_next;
                        a_reg <= PW'(sum_mag);
                        b_reg <= BW'(sum_mag);
                    end
                    P_SS:
                    begin
                        unstable_reg <= (lhs_reg - acc_next) > rhs_reg;
                        b_reg <= BW'(sum_mag);
                        rem_reg <= '0;
                        quo_reg <= '0;
                    end
                    default:
                    begin
                        a_reg <= a_reg;
                    end
                endcase
            end
        end
    end

    assign sts.done = (phase_reg == P_DONE);
    assign sts.unstable = unstable_reg;
    assign mean = sum_reg[SW-1] ? DATA_W'(-quo_reg) : quo_reg[DATA_W-1:0];

endmodule

@@ design/wrench_window_stability_check.sv @@
// Six-axis force/torque window stability checker.
// Input channel (in_valid/in_ready) carries either a sensor sample (kind 0)
// or a check request (kind 1). Samples are written to the window and may
// arrive back to back; samples flagged not_finite are dropped.
// A check request produces one word on the output channel (out_valid/
// out_ready): status, sample count and the six window means.
// For a too-few or stale answer the sequencer goes straight to its done state.
// A full check walks the window one slot per cycle in six parallel lanes,
// then each lane runs a shift-add multiplier (four products) and a restoring
// divider one bit per cycle (operand width is 32 + clog2(WINDOW_DEPTH+1)).
// In both cases the word is loaded once the output register is free, and
// in_ready returns as the word is loaded.
// No new word is taken while a check is in progress.
// The configuration channel (cfg_valid/cfg_ready) is always ready;
// out-of-range values are ignored.
// Reset empties the window and loads the default register values.
// If the receiver stalls, the result is held in the output register and
// samples keep being accepted; the next check waits for the register.
module wrench_window_stability_check import wwsc_pkg::*; #(
    parameter int WINDOW_DEPTH = 1024,
    parameter int FRACTION_BITS = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 kind,
    input  logic [STAMP_W-1:0]   time_stamp,
    input  logic                 not_finite,
    input  logic signed [DATA_W-1:0] force_x,
    input  logic signed [DATA_W-1:0] force_y,
    input  logic signed [DATA_W-1:0] force_z,
    input  logic signed [DATA_W-1:0] torque_x,
    input  logic signed [DATA_W-1:0] torque_y,
    input  logic signed [DATA_W-1:0] torque_z,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [STATUS_W-1:0]  status,
    output logic [COUNT_W-1:0]   sample_count,
    output logic signed [DATA_W-1:0] mean_force_x,
    output logic signed [DATA_W-1:0] mean_force_y,
    output logic signed [DATA_W-1:0] mean_force_z,
    output logic signed [DATA_W-1:0] mean_torque_x,
    output logic signed [DATA_W-1:0] mean_torque_y,
    output logic signed [DATA_W-1:0] mean_torque_z,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [IDX_W-1:0]     cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    localparam int AW = $clog2(WINDOW_DEPTH);
    localparam int CW = $clog2(WINDOW_DEPTH + 1);
    localparam int MW = ((CW > COUNT_W) ? CW : COUNT_W) + 1;
    localparam int LW = CFG_W + 24;
    localparam logic [LW-1:0] DEV_MAX = LW'(64'd1000 << FRACTION_BITS);
    localparam logic [CFG_W-1:0] FORCE_RST = CFG_W'(64'd2 << FRACTION_BITS);
    localparam logic [CFG_W-1:0] TORQUE_RST = CFG_W'((64'd1 << FRACTION_BITS) / 5);
    localparam logic [CW-1:0] DEPTH_N = CW'(WINDOW_DEPTH);
    localparam logic [AW-1:0] LAST_SLOT = AW'(WINDOW_DEPTH - 1);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_WALK = 3'd1;
    localparam logic [2:0] S_DRAIN = 3'd2;
    localparam logic [2:0] S_POST = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;

    logic [COUNT_W-1:0] fws_reg, mss_reg;
    logic [CFG_W-1:0] fdev_reg, tdev_reg, tmo_reg;
    logic [AW-1:0] wp_reg, rd_addr_reg;
    logic [CW-1:0] fill_reg, fill_eff, cap, n_reg, rd_cnt_reg;
    logic [STAMP_W-1:0] newest_reg, age;
    logic [2:0] state_reg;
    logic [1:0] drain_reg;
    logic [STATUS_W-1:0] pend_status_reg;
    logic [COUNT_W-1:0] wmax;
    logic [CW:0] start_sum;
    logic [AW-1:0] start_slot;
    logic in_fire, sample_wr, stale, all_done, any_unstable, out_load;
    lane_ctl_t ctl;
    lane_sts_t sts [LANES];
    logic [DATA_W-1:0] lane_data [LANES];
    logic [DATA_W-1:0] lane_mean [LANES];
    logic [DATA_W-1:0] res_mean_reg [LANES];

    assign cfg_ready = 1'b1;

    // configuration registers with range check
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fws_reg <= COUNT_W'(10);
            mss_reg <= COUNT_W'(20);
            fdev_reg <= FORCE_RST;
            tdev_reg <= TORQUE_RST;
            tmo_reg <= CFG_W'(1000000);
        end
        else if (cfg_valid && cfg_data != '0)
        begin
            case (cfg_index)
                REG_WINDOW:
                    if (cfg_data <= COUNT_MAX) fws_reg <= cfg_data[COUNT_W-1:0];
                REG_MIN_STABLE:
                    if (cfg_data <= COUNT_MAX) mss_reg <= cfg_data[COUNT_W-1:0];
                REG_FORCE_DEV:
                    if (LW'(cfg_data) <= DEV_MAX) fdev_reg <= cfg_data;
                REG_TORQUE_DEV:
                    if (LW'(cfg_data) <= DEV_MAX) tdev_reg <= cfg_data;
                REG_TIMEOUT:
                    if (cfg_data <= TIMEOUT_MAX) tmo_reg <= cfg_data;
                default:
                    tmo_reg <= tmo_reg;
            endcase
        end
    end

    // window capacity and clamped fill
    assign wmax = (fws_reg > mss_reg) ? fws_reg : mss_reg;
    assign cap = (MW'(wmax) > MW'(DEPTH_N)) ? DEPTH_N : CW'(wmax);
    assign fill_eff = (fill_reg > cap) ? cap : fill_reg;

    // oldest slot of the window
    assign start_sum = (CW + 1)'(wp_reg) + (CW + 1)'(DEPTH_N) - (CW + 1)'(fill_eff);
    assign start_slot = (start_sum >= (CW + 1)'(DEPTH_N))
                        ? AW'(start_sum - (CW + 1)'(DEPTH_N)) : AW'(start_sum);

    assign age = time_stamp - newest_reg;
    assign stale = (time_stamp > newest_reg) && (age > STAMP_W'(tmo_reg));

    assign in_ready = (state_reg == S_IDLE);
    assign in_fire = in_valid && in_ready;
    assign sample_wr = in_fire && !kind && !not_finite;
    assign out_load = (state_reg == S_DONE) && (!out_valid || out_ready);

    // window pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= '0;
            fill_reg <= '0;
            newest_reg <= '0;
        end
        else
        begin
            fill_reg <= fill_eff;
            if (sample_wr)
            begin
                wp_reg <= (wp_reg == LAST_SLOT) ? '0 : wp_reg + 1'b1;
                if (fill_eff < cap)
                begin
                    fill_reg <= fill_eff + 1'b1;
                end
                newest_reg <= time_stamp;
            end
        end
    end

    // check sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            out_valid <= 1'b0;
            drain_reg <= '0;
            rd_cnt_reg <= '0;
            n_reg <= '0;
            rd_addr_reg <= '0;
            pend_status_reg <= ST_ACCEPTED;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                out_valid <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                    if (in_fire && kind)
                    begin
                        n_reg <= fill_eff;
                        if (MW'(fill_eff) < MW'(mss_reg))
                        begin
                            pend_status_reg <= ST_TOO_FEW;
                            state_reg <= S_DONE;
                        end
                        else if (stale)
                        begin
                            pend_status_reg <= ST_STALE;
                            state_reg <= S_DONE;
                        end
                        else
                        begin
                            rd_addr_reg <= start_slot;
                            rd_cnt_reg <= '0;
                            state_reg <= S_WALK;
                        end
                    end
                S_WALK:
                begin
                    rd_addr_reg <= (rd_addr_reg == LAST_SLOT) ? '0 : rd_addr_reg + 1'b1;
                    rd_cnt_reg <= rd_cnt_reg + 1'b1;
                    if (rd_cnt_reg == n_reg - 1'b1)
                    begin
                        drain_reg <= '0;
                        state_reg <= S_DRAIN;
                    end
                end
                S_DRAIN:
                begin
                    drain_reg <= drain_reg + 1'b1;
                    if (drain_reg == 2'd3)
                    begin
                        state_reg <= S_POST;
                    end
                end
                S_POST:
                    if (all_done)
                    begin
                        pend_status_reg <= any_unstable ? ST_UNSTABLE : ST_ACCEPTED;
                        state_reg <= S_DONE;
                    end
                S_DONE:
                    if (out_load)
                    begin
                        out_valid <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    assign ctl.clr = in_fire && kind;
    assign ctl.rd = (state_reg == S_WALK);
    assign ctl.start = (state_reg == S_DRAIN) && (drain_reg == 2'd3);

    assign lane_data[0] = force_x;
    assign lane_data[1] = force_y;
    assign lane_data[2] = force_z;
    assign lane_data[3] = torque_x;
    assign lane_data[4] = torque_y;
    assign lane_data[5] = torque_z;

    // one lane per axis
    for (genvar g = 0; g < LANES; g++)
    begin : g_lane
        wwsc_lane #(.WINDOW_DEPTH(WINDOW_DEPTH)) u_lane (
            .clk     (clk),
            .rst_n   (rst_n),
            .wr_en   (sample_wr),
            .wr_addr (wp_reg),
            .wr_data (lane_data[g]),
            .rd_addr (rd_addr_reg),
            .ctl     (ctl),
            .n       (n_reg),
            .thr     ((g < 3) ? fdev_reg : tdev_reg),
            .sts     (sts[g]),
            .mean    (lane_mean[g])
        );
    end

    // merge lane results
    always_comb
    begin
        all_done = 1'b1;
        any_unstable = 1'b0;
        for (int i = 0; i < LANES; i++)
        begin
            all_done = all_done & sts[i].done;
            any_unstable = any_unstable | sts[i].unstable;
        end
    end

    // output word register
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            status <= pend_status_reg;
            sample_count <= COUNT_W'(n_reg);
            for (int i = 0; i < LANES; i++)
            begin
                res_mean_reg[i] <= (pend_status_reg == ST_ACCEPTED) ? lane_mean[i] : '0;
            end
        end
    end

    assign mean_force_x = res_mean_reg[0];
    assign mean_force_y = res_mean_reg[1];
    assign mean_force_z = res_mean_reg[2];
    assign mean_torque_x = res_mean_reg[3];
    assign mean_torque_y = res_mean_reg[4];
    assign mean_torque_z = res_mean_reg[5];

endmodule

@@ test/wrench_window_stability_check_test.sv @@
`timescale 1ns / 1ps

module wrench_window_stability_check_test;
    import wwsc_pkg::*;

    localparam int DEPTH = 1024;
    localparam longint unsigned DEV_LIMIT = 64'd1000 << 16;
    localparam int WATCH_LIMIT = 20000;
    localparam int HOLD_CYCLES = 400;

    typedef struct {
        logic kind;
        logic [STAMP_W-1:0] stamp;
        logic bad;
        logic signed [DATA_W-1:0] ax [LANES];
    } sensor_word_t;

    typedef struct {
        logic [STATUS_W-1:0] st;
        logic [COUNT_W-1:0] cnt;
        logic signed [DATA_W-1:0] mean [LANES];
    } verdict_t;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    logic kind;
    logic [STAMP_W-1:0] time_stamp;
    logic not_finite;
    logic signed [DATA_W-1:0] force_x, force_y, force_z;
    logic signed [DATA_W-1:0] torque_x, torque_y, torque_z;
    logic out_valid;
    logic out_ready = 1'b0;
    logic [STATUS_W-1:0] status;
    logic [COUNT_W-1:0] sample_count;
    logic signed [DATA_W-1:0] mean_force_x, mean_force_y, mean_force_z;
    logic signed [DATA_W-1:0] mean_torque_x, mean_torque_y, mean_torque_z;
    logic cfg_valid;
    logic cfg_ready;
    logic [IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0] cfg_data;

    wrench_window_stability_check dut (.*);

    // window predictor state
    logic signed [DATA_W-1:0] win_data [LANES][DEPTH];
    int unsigned wr_ptr;
    int unsigned fill_cnt;
    logic [STAMP_W-1:0] last_stamp;
    int unsigned cfg_win;
    int unsigned cfg_min;
    longint unsigned cfg_fdev;
    longint unsigned cfg_tdev;
    longint unsigned cfg_timeout;

    verdict_t pending [$];
    string axis_name [LANES] = '{"mean_force_x", "mean_force_y", "mean_force_z",
                                 "mean_torque_x", "mean_torque_y", "mean_torque_z"};

    int errs = 0;
    int words_sent = 0;
    int results_seen = 0;
    int status_hits [4] = '{0, 0, 0, 0};
    int send_gap_pct = 0;
    int recv_stall_pct = 0;
    int hold_left = 0;
    int quiet_cycles = 0;

    // random stimulus shaping
    logic [STAMP_W-1:0] clock_us;
    logic signed [DATA_W-1:0] level [LANES];
    int unsigned jitter;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic int unsigned win_cap();
        int unsigned c;
        c = (cfg_win > cfg_min) ? cfg_win : cfg_min;
        if (c < 1) c = 1;
        if (c > DEPTH) c = DEPTH;
        return c;
    endfunction

    function automatic void window_reset();
        wr_ptr = 0;
        fill_cnt = 0;
        last_stamp = '0;
        cfg_win = 10;
        cfg_min = 20;
        cfg_fdev = 64'd2 << 16;
        cfg_tdev = (64'd1 << 16) / 5;
        cfg_timeout = 1000000;
    endfunction

    // register write with range filtering and window shrink
    function automatic void window_config(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] val);
        case (idx)
            REG_WINDOW: if (val >= 1 && val <= COUNT_MAX) cfg_win = val;
            REG_MIN_STABLE: if (val >= 1 && val <= COUNT_MAX) cfg_min = val;
            REG_FORCE_DEV: if (val >= 1 && val <= DEV_LIMIT) cfg_fdev = val;
            REG_TORQUE_DEV: if (val >= 1 && val <= DEV_LIMIT) cfg_tdev = val;
            REG_TIMEOUT: if (val >= 1 && val <= TIMEOUT_MAX) cfg_timeout = val;
            default: return;
        endcase
        if (fill_cnt > win_cap()) fill_cnt = win_cap();
    endfunction

    // store a sample or work out the verdict of a check
    function automatic void window_step(sensor_word_t w);
        verdict_t v;
        logic signed [127:0] s, sq, x, nn, thr, lhs, rhs;
        logic signed [127:0] sums [LANES];
        int unsigned start;
        int unsigned slot;
        logic shaky;
        if (!w.kind) begin
            if (w.bad) return;
            for (int l = 0; l < LANES; l++) win_data[l][wr_ptr] = w.ax[l];
            wr_ptr = (wr_ptr + 1) % DEPTH;
            if (fill_cnt < win_cap()) fill_cnt++;
            last_stamp = w.stamp;
            return;
        end
        v.st = ST_ACCEPTED;
        v.cnt = fill_cnt[COUNT_W-1:0];
        for (int l = 0; l < LANES; l++) v.mean[l] = '0;
        if (fill_cnt < cfg_min) begin
            v.st = ST_TOO_FEW;
        end else if (w.stamp > last_stamp && w.stamp - last_stamp > cfg_timeout) begin
            v.st = ST_STALE;
        end else begin
            shaky = 1'b0;
            start = (wr_ptr + DEPTH - fill_cnt) % DEPTH;
            nn = fill_cnt;
            for (int l = 0; l < LANES; l++) begin
                s = 0;
                sq = 0;
                for (int unsigned k = 0; k < fill_cnt; k++) begin
                    slot = (start + k) % DEPTH;
                    x = win_data[l][slot];
                    s += x;
                    sq += x * x;
                end
                sums[l] = s;
                thr = (l < 3) ? cfg_fdev : cfg_tdev;
                lhs = nn * sq - s * s;
                rhs = (nn * thr) * (nn * thr);
                if (lhs > rhs) shaky = 1'b1;
            end
            if (shaky) begin
                v.st = ST_UNSTABLE;
            end else begin
                for (int l = 0; l < LANES; l++) v.mean[l] = 32'(sums[l] / nn);
            end
        end
        pending.insert(pending.size(), v);
    endfunction

    // result checker, receiver stall and watchdog
    always @(posedge clk)
    begin
        verdict_t e;
        logic signed [DATA_W-1:0] got [LANES];
        got = '{mean_force_x, mean_force_y, mean_force_z,
                mean_torque_x, mean_torque_y, mean_torque_z};
        if (rst_n && out_valid && out_ready) begin
            results_seen++;
            if (pending.size() == 0) begin
                $error("result word with nothing expected, status %0d", status);
                errs++;
            end else begin
                e = pending[0];
                pending.delete(0);
                status_hits[e.st]++;
                if (status !== e.st) begin
                    $error("status expected %0d got %0d", e.st, status);
                    errs++;
                end
                if (sample_count !== e.cnt) begin
                    $error("sample_count expected %0d got %0d", e.cnt, sample_count);
                    errs++;
                end
                for (int l = 0; l < LANES; l++) begin
                    if (got[l] !== e.mean[l]) begin
                        $error("%s expected %0d got %0d", axis_name[l], e.mean[l], got[l]);
                        errs++;
                    end
                end
            end
        end
        if (hold_left > 0) begin
            hold_left--;
            out_ready <= 1'b0;
        end else begin
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCH_LIMIT) begin
            $display("wrench_window_stability_check_test: errors");
            $finish;
        end
    end

    // offer one word, with a random gap ahead of it
    task automatic send_word(input sensor_word_t w);
        if ($urandom_range(99) < send_gap_pct) begin
            in_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < send_gap_pct);
        end
        kind <= w.kind;
        time_stamp <= w.stamp;
        not_finite <= w.bad;
        force_x <= w.ax[0];
        force_y <= w.ax[1];
        force_z <= w.ax[2];
        torque_x <= w.ax[3];
        torque_y <= w.ax[4];
        torque_z <= w.ax[5];
        in_valid <= 1'b1;
        do @(posedge clk); while (!in_ready);
        window_step(w);
        words_sent++;
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending.size() != 0) @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        cfg_index <= idx;
        cfg_data <= val;
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
        window_config(idx, val);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    function automatic sensor_word_t flat_word(logic k, logic [STAMP_W-1:0] ts,
                                               logic signed [DATA_W-1:0] val);
        sensor_word_t w;
        w.kind = k;
        w.stamp = ts;
        w.bad = 1'b0;
        for (int l = 0; l < LANES; l++) w.ax[l] = val;
        return w;
    endfunction

    function automatic sensor_word_t noisy_word();
        sensor_word_t w;
        w.kind = 1'($urandom_range(1));
        w.bad = 1'($urandom_range(1));
        w.stamp = STAMP_W'({$urandom, $urandom});
        for (int l = 0; l < LANES; l++) w.ax[l] = $urandom;
        return w;
    endfunction

    function automatic sensor_word_t near_sample();
        sensor_word_t w;
        clock_us += STAMP_W'($urandom_range(1, 2000));
        w.kind = 1'b0;
        w.bad = 1'b0;
        w.stamp = clock_us;
        for (int l = 0; l < LANES; l++)
            w.ax[l] = level[l] + 32'($urandom_range(0, 2 * jitter)) - 32'(jitter);
        return w;
    endfunction

    function automatic sensor_word_t check_word();
        sensor_word_t w;
        int unsigned pick;
        w = noisy_word();
        w.kind = 1'b1;
        pick = $urandom_range(9);
        if (pick < 6)
            w.stamp = clock_us + STAMP_W'($urandom_range(0, 32'(cfg_timeout)));
        else if (pick < 8)
            w.stamp = STAMP_W'(clock_us + cfg_timeout + 1 + $urandom_range(0, 1000000));
        else if (pick == 8)
            w.stamp = clock_us - STAMP_W'($urandom_range(0, 5000));
        return w;
    endfunction

    function automatic void pick_levels();
        for (int l = 0; l < LANES; l++)
            level[l] = ($urandom_range(3) == 0) ? $urandom
                                                : 32'($urandom_range(0, 2000000)) - 32'd1000000;
        jitter = $urandom_range(1) ? $urandom_range(0, 20000) : $urandom_range(0, 600000);
    endfunction

    // field extremes, register ranges, stale edge and rounding
    task automatic test_corners();
        sensor_word_t w;
        send_word(flat_word(1'b1, '0, '0));
        w = flat_word(1'b0, 48'd5, 32'sd9);
        w.bad = 1'b1;
        send_word(w);
        settle();
        write_reg(REG_WINDOW, 26'd1);
        write_reg(REG_MIN_STABLE, 26'd1);
        send_word(flat_word(1'b0, '1, 32'h7fff_ffff));
        send_word(flat_word(1'b1, '0, '0));
        send_word(flat_word(1'b0, 48'd100, 32'h8000_0000));
        send_word(flat_word(1'b1, 48'd1000100, '0));
        send_word(flat_word(1'b1, 48'd1000101, '0));
        settle();
        write_reg(REG_WINDOW, 26'd2);
        write_reg(REG_MIN_STABLE, 26'd2);
        send_word(flat_word(1'b0, 48'd200, -32'sd3));
        send_word(flat_word(1'b0, 48'd201, -32'sd4));
        send_word(flat_word(1'b1, 48'd202, '0));
        send_word(flat_word(1'b0, 48'd203, 32'h7fff_ffff));
        send_word(flat_word(1'b0, 48'd204, 32'h8000_0000));
        send_word(flat_word(1'b1, 48'd205, '0));
        settle();
        // tightest and loosest limits
        write_reg(REG_FORCE_DEV, 26'd1);
        write_reg(REG_TORQUE_DEV, 26'd1);
        send_word(flat_word(1'b0, 48'd300, 32'sd0));
        send_word(flat_word(1'b0, 48'd301, 32'sd1));
        send_word(flat_word(1'b1, 48'd301, '0));
        send_word(flat_word(1'b0, 48'd302, 32'sd3));
        send_word(flat_word(1'b1, 48'd302, '0));
        settle();
        write_reg(REG_FORCE_DEV, 26'd65536000);
        write_reg(REG_TORQUE_DEV, 26'd65536000);
        send_word(flat_word(1'b1, 48'd303, '0));
        settle();
        // values out of range are dropped
        write_reg(REG_WINDOW, 26'd0);
        write_reg(REG_WINDOW, 26'd1001);
        write_reg(REG_MIN_STABLE, 26'd0);
        write_reg(REG_FORCE_DEV, 26'd0);
        write_reg(REG_FORCE_DEV, 26'd65536001);
        write_reg(REG_TORQUE_DEV, 26'h3ff_ffff);
        write_reg(REG_TIMEOUT, 26'd0);
        write_reg(REG_TIMEOUT, 26'd60000001);
        write_reg(REG_TIMEOUT, 26'd1);
        send_word(flat_word(1'b0, 48'd1000, 32'sd7));
        send_word(flat_word(1'b1, 48'd1001, '0));
        send_word(flat_word(1'b1, 48'd1002, '0));
        settle();
        write_reg(REG_TIMEOUT, 26'd60000000);
        write_reg(REG_FORCE_DEV, 26'd131072);
        write_reg(REG_TORQUE_DEV, 26'd13107);
    endtask

    // random epochs, each under a fresh register setting
    task automatic test_random(input int count, input int gap, input int stall);
        int unsigned r;
        send_gap_pct = gap;
        recv_stall_pct = stall;
        repeat (count / 60) begin
            settle();
            write_reg(REG_WINDOW, $urandom_range(0, 9) == 0 ? 26'd0
                                                           : CFG_W'($urandom_range(1, 24)));
            write_reg(REG_MIN_STABLE, CFG_W'($urandom_range(1, 26)));
            write_reg(REG_FORCE_DEV, CFG_W'($urandom_range(1, 400000)));
            write_reg(REG_TORQUE_DEV, $urandom_range(0, 9) == 0 ? 26'h3ff_ffff
                                                               : CFG_W'($urandom_range(1, 400000)));
            write_reg(REG_TIMEOUT, CFG_W'($urandom_range(1000, 200000)));
            pick_levels();
            if ($urandom_range(4) == 0) clock_us = STAMP_W'({$urandom, $urandom});
            repeat (60) begin
                r = $urandom_range(99);
                if (r < 9)
                    send_word(check_word());
                else if (r < 19)
                    send_word(noisy_word());
                else
                    send_word(near_sample());
            end
        end
    endtask

    // long receiver hold so the output fills and the input stalls
    task automatic test_backpressure();
        settle();
        send_gap_pct = 0;
        recv_stall_pct = 0;
        write_reg(REG_WINDOW, 26'd12);
        write_reg(REG_MIN_STABLE, 26'd4);
        write_reg(REG_TIMEOUT, 26'd60000000);
        jitter = 50;
        hold_left = HOLD_CYCLES;
        repeat (3) begin
            repeat (8) send_word(near_sample());
            send_word(check_word());
        end
        repeat (5) send_word(near_sample());
        // sender waits for every verdict before going on
        settle();
        send_word(check_word());
        settle();
    endtask

    // widest window, then a shrink that drops old samples
    task automatic test_wide_window();
        settle();
        send_gap_pct = 0;
        recv_stall_pct = 10;
        write_reg(REG_WINDOW, 26'd1000);
        write_reg(REG_MIN_STABLE, 26'd1000);
        write_reg(REG_TIMEOUT, 26'd60000000);
        write_reg(REG_FORCE_DEV, 26'd65536000);
        write_reg(REG_TORQUE_DEV, 26'd65536000);
        pick_levels();
        repeat (40) send_word(near_sample());
        send_word(check_word());
        settle();
        write_reg(REG_MIN_STABLE, 26'd1);
        repeat (200) send_word(near_sample());
        send_word(check_word());
        settle();
        write_reg(REG_WINDOW, 26'd3);
        write_reg(REG_MIN_STABLE, 26'd3);
        send_word(check_word());
        settle();
        write_reg(REG_WINDOW, 26'd1);
        write_reg(REG_MIN_STABLE, 26'd1000);
        send_word(near_sample());
        send_word(check_word());
        settle();
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        kind = 1'b0;
        time_stamp = '0;
        not_finite = 1'b0;
        force_x = '0;
        force_y = '0;
        force_z = '0;
        torque_x = '0;
        torque_y = '0;
        torque_z = '0;
        cfg_valid = 1'b0;
        cfg_index = REG_WINDOW;
        cfg_data = '0;
        clock_us = '0;
        jitter = 0;
        for (int l = 0; l < LANES; l++) level[l] = '0;
        window_reset();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_corners();
        test_random(330, 19, 84);
        test_backpressure();
        test_random(330, 84, 19);
        test_wide_window();
        test_random(330, 0, 0);
        settle();
        repeat (50) @(posedge clk);

        $display("covered %0d words, %0d verdicts: accepted %0d, too few %0d, stale %0d, unstable %0d",
                 words_sent, results_seen, status_hits[ST_ACCEPTED], status_hits[ST_TOO_FEW],
                 status_hits[ST_STALE], status_hits[ST_UNSTABLE]);
        if (errs == 0 && pending.size() == 0)
            $display("wrench_window_stability_check_test: clean");
        else
            $display("wrench_window_stability_check_test: errors");
        $finish;
    end

endmodule
